@@ sv/mlpq_pkg.sv @@
// Package for the multilevel priority ready queue: request/result structs, codes, FSM states.
// No dependencies.
package mlpq_pkg;

    typedef enum logic [1:0] {
        FUNC_ENQ   = 2'd0,
        FUNC_DEQ   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_RSVD  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DROPPED = 2'd2,
        ST_RSVD    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  level;
        logic [15:0] task_id;
        logic [3:0]  task_priority;
    } req_t;

    typedef struct packed {
        logic [15:0] out_task_id;
        logic [3:0]  out_priority;
        logic [2:0]  placed_level;
        logic [1:0]  status;
        logic        level_empty;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

@@ sv/multilevel_priority_ready_queue_top.sv @@
// Multilevel priority ready queue: top level with entry memory and sequencer.
// Depends on mlpq_pkg.
//
// channel | dir | ports              | payload
// --------+-----+--------------------+---------------------
// request | in  | s_valid / s_ready  | s_req  (mlpq_pkg::req_t)
// result  | out | m_valid / m_ready  | m_rsp  (mlpq_pkg::rsp_t)
//
// Timing: the enqueue spill walk checks one level per cycle (counts are flops).
// Dequeue scans the level through the single memory read port, one entry per cycle,
// then shifts the tail down one entry at a time: each moved entry is read, then
// written one slot lower.
// Reset: aresetn synchronous, clears counts and control; entry memory is not cleared.
// Stalls: one request at a time; a held result blocks the next request until taken.
module multilevel_priority_ready_queue_top #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int LEVEL_COUNT  = 8,
    parameter int TOP_PRIORITY = 7
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mlpq_pkg::req_t  s_req,
    output logic            m_valid,
    input  logic            m_ready,
    output mlpq_pkg::rsp_t  m_rsp
);
    import mlpq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;  // index in level
    localparam int CW = $clog2(QUEUE_DEPTH + 1);                      // count
    localparam int LW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
    localparam int LX = LW + 1;                                       // level incl. overflow
    localparam int SLOTS = QUEUE_DEPTH * LEVEL_COUNT;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [3:0] TOP_P = 4'(TOP_PRIORITY);

    // entry memory {id, priority}, one write and one registered read port
    logic [19:0] mem [SLOTS];
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [19:0] wr_data, rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    logic [CW-1:0] cnt_reg [LEVEL_COUNT];

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [LX-1:0] lvl_reg, lvl_next;       // walk level during enqueue
    logic [3:0]    prio_reg, prio_next;
    logic [CW-1:0] idx_reg, idx_next;       // scan / shift position
    logic          rd_pend_reg, rd_pend_next;
    logic [IW-1:0] best_reg, best_next;
    logic [19:0]   best_dat_reg, best_dat_next;
    rsp_t          rsp_reg, rsp_next;
    logic          cnt_we;
    logic [LW-1:0] cnt_lvl;
    logic [CW-1:0] cnt_val;

    logic          lvl_ok, walk_ok;
    logic [CW-1:0] cur_cnt, walk_cnt;
    logic [AW-1:0] base;

    assign lvl_ok  = 32'(req_reg.level) < 32'(LEVEL_COUNT);
    assign cur_cnt = lvl_ok ? cnt_reg[LW'(req_reg.level)] : '0;
    assign walk_ok = 32'(lvl_reg) < 32'(LEVEL_COUNT);
    assign walk_cnt = walk_ok ? cnt_reg[lvl_reg[LW-1:0]] : '0;
    assign base    = AW'(32'(req_reg.level) * QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < LEVEL_COUNT; i++) cnt_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cnt_we) cnt_reg[cnt_lvl] <= cnt_val;
        end
        req_reg      <= req_next;
        lvl_reg      <= lvl_next;
        prio_reg     <= prio_next;
        idx_reg      <= idx_next;
        rd_pend_reg  <= rd_pend_next;
        best_reg     <= best_next;
        best_dat_reg <= best_dat_next;
        rsp_reg      <= rsp_next;
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        lvl_next      = lvl_reg;
        prio_next     = prio_reg;
        idx_next      = idx_reg;
        rd_pend_next  = rd_pend_reg;
        best_next     = best_reg;
        best_dat_next = best_dat_reg;
        rsp_next      = rsp_reg;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_addr = base + AW'(idx_reg[IW-1:0]);
        cnt_we  = 1'b0;
        cnt_lvl = '0;
        cnt_val = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next  = s_req;
                    lvl_next  = LX'(s_req.level);
                    prio_next = s_req.task_priority;
                    idx_next  = '0;
                    rd_pend_next = 1'b0;
                    best_next = '0;
                    unique case (func_t'(s_req.func))
                        FUNC_ENQ: state_next = S_ENQ;
                        FUNC_DEQ: state_next = S_SCAN;
                        default: begin
                            rsp_next = '0;
                            rsp_next.placed_level = s_req.level;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ENQ: begin
                // one level per cycle
                rsp_next = '0;
                if (!walk_ok) begin
                    rsp_next.status = ST_DROPPED;
                    state_next = S_DONE;
                end else if (32'(walk_cnt) >= QUEUE_DEPTH) begin
                    if (prio_reg < TOP_P) begin
                        prio_next = prio_reg + 4'd1;
                        lvl_next  = lvl_reg + LX'(1);
                    end else begin
                        rsp_next.status = ST_DROPPED;
                        state_next = S_DONE;
                    end
                end else if (prio_reg <= TOP_P) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(32'(lvl_reg) * QUEUE_DEPTH) + AW'(walk_cnt);
                    wr_data = {req_reg.task_id, prio_reg};
                    cnt_we  = 1'b1;
                    cnt_lvl = lvl_reg[LW-1:0];
                    cnt_val = walk_cnt + CW'(1);
                    rsp_next.out_priority = prio_reg;
                    rsp_next.placed_level = 3'(lvl_reg);
                    state_next = S_DONE;
                end else begin
                    rsp_next.status = ST_DROPPED;
                    state_next = S_DONE;
                end
            end
            S_SCAN: begin
                // idx_reg = address issued this cycle; rd_pend: data of idx-1 valid
                if (rd_pend_reg) begin
                    if (idx_reg == CW'(1) || best_dat_reg[3:0] < rd_data_reg[3:0]) begin
                        best_next     = IW'(idx_reg - CW'(1));
                        best_dat_next = rd_data_reg;
                    end
                end
                if (cur_cnt == '0) begin
                    rsp_next = '0;
                    rsp_next.placed_level = req_reg.level;
                    rsp_next.status = ST_EMPTY;
                    state_next = S_DONE;
                end else if (idx_reg == cur_cnt) begin
                    idx_next = CW'(best_next) + CW'(1);
                    rd_pend_next = 1'b0;
                    state_next = S_SHIFT;
                end else begin
                    idx_next = idx_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
            end
            S_SHIFT: begin
                // read entry idx, then write it to idx-1
                if (idx_reg >= cur_cnt) begin
                    cnt_we  = 1'b1;
                    cnt_lvl = LW'(req_reg.level);
                    cnt_val = cur_cnt - CW'(1);
                    rsp_next = '0;
                    rsp_next.out_task_id  = best_dat_reg[19:4];
                    rsp_next.out_priority = best_dat_reg[3:0];
                    rsp_next.placed_level = req_reg.level;
                    rsp_next.level_empty  = (cur_cnt == CW'(1));
                    state_next = S_DONE;
                end else if (!rd_pend_reg) begin
                    rd_pend_next = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = base + AW'(idx_reg - CW'(1));
                    wr_data = rd_data_reg;
                    idx_next = idx_reg + CW'(1);
                    rd_pend_next = 1'b0;
                end
            end
            S_DONE: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // level_empty reflects counts after the operation (counts settled by S_DONE)
    always_comb begin
        m_rsp = rsp_reg;
        m_rsp.level_empty = (cur_cnt == '0);
    end

    // result and request never both offered
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid together");
    // a level count never exceeds the depth
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> 32'(cnt_val) <= QUEUE_DEPTH) else $error("count overflow");
    // dropped enqueue reports zero fields
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == ST_DROPPED) |-> (m_rsp.out_priority == '0
        && m_rsp.placed_level == '0)) else $error("dropped fields nonzero");
    // result stays valid while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result lost");

endmodule

@@ tb/multilevel_priority_ready_queue_top_test.sv @@
// Testbench for multilevel_priority_ready_queue_top: random and directed requests with a
// cycle-accurate-free queue predictor and in-order result checking.
// Depends on mlpq_pkg and the block's RTL.
`timescale 1ns / 1ps

module multilevel_priority_ready_queue_top_test;
    import mlpq_pkg::*;

    localparam int DEPTH    = 16;
    localparam int LEVELS   = 8;
    localparam int TOP_PRIO = 7;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int HOLD_AFTER      = 600;   // results seen before the long stall
    localparam int HOLD_CYCLES     = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    multilevel_priority_ready_queue_top #(
        .QUEUE_DEPTH(DEPTH), .LEVEL_COUNT(LEVELS), .TOP_PRIORITY(TOP_PRIO)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    always #2 aclk = ~aclk;

    // Shadow of the queue bank, kept at the block's widths.
    logic [15:0] shadow_ids   [LEVELS][DEPTH];
    logic [3:0]  shadow_prios [LEVELS][DEPTH];
    int          shadow_fill  [LEVELS];

    req_t pending_requests[$];
    rsp_t awaited_results[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   predicted_count = 0;
    int   checked_count = 0;
    int   drive_gap = 0;
    int   ready_gap = 0;
    int   mon_gap = 0;
    int   hold_count = 0;
    logic hold_done = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else return $urandom_range(10, 40);
    endfunction

    function automatic req_t make_req(func_t f, int lvl, int id, int prio);
        req_t r;
        r.func          = f;
        r.level         = 3'(lvl);
        r.task_id       = 16'(id);
        r.task_priority = 4'(prio);
        return r;
    endfunction

    // Expected result of one request; updates the shadow bank.
    function automatic rsp_t predict(req_t r);
        rsp_t e;
        int   lvl;
        int   p;
        int   best;
        int   n;
        logic stored;
        logic walking;
        e = '0;
        unique case (func_t'(r.func))
            FUNC_ENQ: begin
                lvl = int'(r.level);
                p = int'(r.task_priority);
                stored = 1'b0;
                walking = 1'b1;
                while (walking) begin
                    if (lvl >= LEVELS) begin
                        walking = 1'b0;
                    end else if (shadow_fill[lvl] >= DEPTH) begin
                        if (p < TOP_PRIO) begin
                            p = p + 1;
                            lvl = lvl + 1;
                        end else begin
                            walking = 1'b0;
                        end
                    end else begin
                        if (p <= TOP_PRIO) begin
                            shadow_ids[lvl][shadow_fill[lvl]]   = r.task_id;
                            shadow_prios[lvl][shadow_fill[lvl]] = 4'(p);
                            shadow_fill[lvl] = shadow_fill[lvl] + 1;
                            stored = 1'b1;
                        end
                        walking = 1'b0;
                    end
                end
                if (stored) begin
                    e.out_priority = 4'(p);
                    e.placed_level = 3'(lvl);
                end else begin
                    e.status = ST_DROPPED;
                end
            end
            FUNC_DEQ: begin
                e.placed_level = r.level;
                lvl = int'(r.level);
                if (lvl >= LEVELS || shadow_fill[lvl] == 0) begin
                    e.status = ST_EMPTY;
                end else begin
                    n = shadow_fill[lvl];
                    best = 0;
                    for (int i = 1; i < n; i++) begin
                        if (shadow_prios[lvl][best] < shadow_prios[lvl][i]) best = i;
                    end
                    e.out_task_id  = shadow_ids[lvl][best];
                    e.out_priority = shadow_prios[lvl][best];
                    for (int i = best; i < n - 1; i++) begin
                        shadow_ids[lvl][i]   = shadow_ids[lvl][i + 1];
                        shadow_prios[lvl][i] = shadow_prios[lvl][i + 1];
                    end
                    shadow_fill[lvl] = n - 1;
                end
            end
            default: begin
                e.placed_level = r.level;
            end
        endcase
        lvl = int'(r.level);
        e.level_empty = (lvl >= LEVELS) || (shadow_fill[lvl] == 0);
        return e;
    endfunction

    task automatic report_mismatch(string what, rsp_t got, rsp_t want);
        $display("mismatch (%s) at cycle %0d: got %h expected %h",
                 what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // stimulus: directed corners first, then random traffic
    initial begin
        int f;
        for (int i = 0; i < LEVELS; i++) shadow_fill[i] = 0;
        pending_requests.push_back(make_req(FUNC_DEQ, 3, 0, 0));
        pending_requests.push_back(make_req(FUNC_QUERY, 0, 0, 0));
        pending_requests.push_back(make_req(FUNC_RSVD, 5, 77, 3));
        // fill level 0, spill two into level 1 with a raised priority
        for (int i = 0; i < 18; i++)
            pending_requests.push_back(make_req(FUNC_ENQ, 0, 100 + i, 6));
        // top off level 1, then one more at top priority is dropped
        for (int i = 0; i < 15; i++)
            pending_requests.push_back(make_req(FUNC_ENQ, 1, 200 + i, 7));
        // priority above the maximum is dropped
        pending_requests.push_back(make_req(FUNC_ENQ, 2, 300, 12));
        // fill the last level, then spill past it
        for (int i = 0; i < 17; i++)
            pending_requests.push_back(make_req(FUNC_ENQ, 7, 400 + i, 3));
        // drain level 0 and one more on the empty level
        for (int i = 0; i < 17; i++)
            pending_requests.push_back(make_req(FUNC_DEQ, 0, 0, 0));
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            f = $urandom_range(0, 99);
            if (f < 55)
                pending_requests.push_back(make_req(FUNC_ENQ, $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 9)));
            else if (f < 85)
                pending_requests.push_back(make_req(FUNC_DEQ, $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 15)));
            else if (f < 95)
                pending_requests.push_back(make_req(FUNC_QUERY, $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 15)));
            else
                pending_requests.push_back(make_req(FUNC_RSVD, $urandom_range(0, 7),
                    $urandom_range(0, 65535), $urandom_range(0, 15)));
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_requests.size() != 0 || s_valid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0 && checked_count == predicted_count)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // driver: a request stays put until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drive_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(predict(s_req));
                predicted_count++;
            end
            if (s_valid && !s_ready) begin
                // hold the request
            end else if (drive_gap > 0) begin
                s_valid <= 1'b0;
                drive_gap <= drive_gap - 1;
            end else if (pending_requests.size() > 0) begin
                s_req <= pending_requests.pop_front();
                s_valid <= 1'b1;
                drive_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: random ready gaps, in-order compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", m_rsp, '0);
                end else if (m_rsp !== awaited_results[0]) begin
                    report_mismatch("field", m_rsp, awaited_results.pop_front());
                end else begin
                    void'(awaited_results.pop_front());
                end
                checked_count <= checked_count + 1;
                mon_gap = pick_gap();
                ready_gap <= mon_gap;
                m_ready <= (mon_gap == 0) && (hold_count == 0);
            end else if (hold_count > 0) begin
                m_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap <= ready_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one long receiver stall while the driver keeps offering
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_count <= 0;
        end else if (!hold_done && checked_count >= HOLD_AFTER) begin
            hold_count <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
endmodule
